@@ design/piecewise_linear_table_interpolation_macros.svh @@
// Assertion helpers for the table interpolation block.
`ifndef PIECEWISE_LINEAR_TABLE_INTERPOLATION_MACROS_SVH
`define PIECEWISE_LINEAR_TABLE_INTERPOLATION_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PLTI_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("plti: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PLTI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("plti: next-cycle check failed");

`endif

@@ design/plti_pkg.sv @@
`default_nettype none

package plti_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = 5;
    localparam int PIDX_W     = 4;
    localparam int DATA_W     = 32;
    localparam int ALU_W      = DATA_W + 2;
    localparam int MAG_W      = DATA_W + 1;
    localparam int PROD_W     = 2 * DATA_W;

    localparam int DIV_STEPS  = DATA_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int S_TDATA_W  = 104;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] CLAMP_NONE  = 2'd0;
    localparam logic [1:0] CLAMP_BELOW = 2'd1;
    localparam logic [1:0] CLAMP_ABOVE = 2'd2;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    function automatic logic [ALU_W-1:0] sext_alu(input logic [DATA_W-1:0] v);
        sext_alu = {{(ALU_W - DATA_W){v[DATA_W-1]}}, v};
    endfunction

endpackage

`default_nettype wire

@@ design/piecewise_linear_table_interpolation.sv @@
// Piecewise-linear lookup over a table of up to 16 breakpoints (reference,
// target), both signed Q16.16. A write beat (tuser = 0) stores one breakpoint
// and returns a beat with status 1 and no store when point_index is not below
// the point count; a query beat (tuser = 1) scans the breakpoints in order for
// the first reference above the query, clamps to the first or last target at
// the ends, and otherwise returns v1 + (v2 - v1) * (q - r1) / (r2 - r1), the
// quotient truncated toward zero. The block holds one item at a time: s_tready
// is low from acceptance until the result beat is taken. A write offers its
// result beat in the cycle after acceptance. A query examines the breakpoints
// in turn (one table read port, one entry a cycle); a clamped query offers its
// result when the scan ends, and an interpolated query runs on through
// three difference steps, one multiply and 32 restoring-division steps, the
// differences and division steps on one shared 34-bit add/subtract unit,
// plus the final correction step, also on that unit.
// The table has no reset; query only entries that were written. num_points
// (reset 1) may be written only while idle; 0 acts as 1, above 16 as 16.
`default_nettype none

`include "piecewise_linear_table_interpolation_macros.svh"

module piecewise_linear_table_interpolation (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    // configuration: num_points
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [plti_pkg::CNT_W-1:0]      cfg_data,

    // input beats
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // [3:0] point_index, [35:4] ref_value, [67:36] target_value,
    // [99:68] query_value, [103:100] zero
    input  wire logic [plti_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] opcode
    input  wire logic                            s_tuser,

    // result beats
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // [31:0] result_value, [36:32] segment, [39:37] zero
    output      logic [plti_pkg::M_TDATA_W-1:0]  m_tdata,
    // [1:0] clamp, [2] status
    output      logic [plti_pkg::M_TUSER_W-1:0]  m_tuser
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DR,
        ST_DQ,
        ST_DV,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_OUT
    } state_t;

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic [plti_pkg::PIDX_W-1:0] s_point_index;
    logic [plti_pkg::DATA_W-1:0] s_ref_value;
    logic [plti_pkg::DATA_W-1:0] s_target_value;
    logic [plti_pkg::DATA_W-1:0] s_query_value;

    assign s_point_index  = s_tdata[3:0];
    assign s_ref_value    = s_tdata[35:4];
    assign s_target_value = s_tdata[67:36];
    assign s_query_value  = s_tdata[99:68];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                         state_reg;
    logic [plti_pkg::CNT_W-1:0]     num_points_reg;
    logic [plti_pkg::CNT_W-1:0]     idx_reg;
    logic [plti_pkg::CNT_W-1:0]     idx_next;
    logic [plti_pkg::DATA_W-1:0]    q_reg;
    logic [plti_pkg::DATA_W-1:0]    prev_ref_reg;
    logic [plti_pkg::DATA_W-1:0]    prev_tgt_reg;
    logic [plti_pkg::DATA_W-1:0]    dr_reg;
    logic [plti_pkg::DATA_W-1:0]    dq_reg;
    logic [plti_pkg::MAG_W-1:0]     mag_reg;
    logic                           neg_reg;
    logic [plti_pkg::DATA_W-1:0]    rem_reg;
    logic [plti_pkg::DATA_W-1:0]    quo_reg;
    logic [plti_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [plti_pkg::DATA_W-1:0]    result_reg;
    logic [plti_pkg::CNT_W-1:0]     seg_reg;
    logic [1:0]                     clamp_reg;
    logic                           status_reg;

    // table read data, one entry a cycle
    logic [plti_pkg::DATA_W-1:0]    rd_ref_reg;
    logic [plti_pkg::DATA_W-1:0]    rd_tgt_reg;

    logic [plti_pkg::DATA_W-1:0]    ref_mem [plti_pkg::MAX_POINTS];
    logic [plti_pkg::DATA_W-1:0]    tgt_mem [plti_pkg::MAX_POINTS];

    // ------------------------------------------------------------------
    // Handshake and effective point count
    // ------------------------------------------------------------------
    logic                       s_fire;
    logic [plti_pkg::CNT_W-1:0] n_eff;
    logic                       idx_ok;
    logic                       mem_we;
    logic                       found;
    logic                       last_entry;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign s_fire    = s_tvalid && s_tready;

    always_comb begin
        priority if (num_points_reg == '0) begin
            n_eff = plti_pkg::CNT_W'(1);
        end else if (num_points_reg > plti_pkg::CNT_W'(plti_pkg::MAX_POINTS)) begin
            n_eff = plti_pkg::CNT_W'(plti_pkg::MAX_POINTS);
        end else begin
            n_eff = num_points_reg;
        end
    end

    assign idx_ok = (plti_pkg::CNT_W'(s_point_index) < n_eff);
    assign mem_we = s_fire && (s_tuser == plti_pkg::OP_WRITE) && idx_ok;

    // ------------------------------------------------------------------
    // Shared add/subtract unit: scan compare, differences, division
    // steps and the final correction all go through it.
    // ------------------------------------------------------------------
    logic [plti_pkg::ALU_W-1:0] alu_a;
    logic [plti_pkg::ALU_W-1:0] alu_b;
    logic                       alu_sub;
    logic [plti_pkg::ALU_W-1:0] alu_res;
    logic [plti_pkg::ALU_W-1:0] alu_neg;

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        unique case (state_reg)
            ST_SCAN: begin
                alu_a = plti_pkg::sext_alu(q_reg);
                alu_b = plti_pkg::sext_alu(rd_ref_reg);
            end
            ST_DR: begin
                alu_a = plti_pkg::sext_alu(rd_ref_reg);
                alu_b = plti_pkg::sext_alu(prev_ref_reg);
            end
            ST_DQ: begin
                alu_a = plti_pkg::sext_alu(q_reg);
                alu_b = plti_pkg::sext_alu(prev_ref_reg);
            end
            ST_DV: begin
                alu_a = plti_pkg::sext_alu(rd_tgt_reg);
                alu_b = plti_pkg::sext_alu(prev_tgt_reg);
            end
            ST_DIV: begin
                alu_a = {1'b0, rem_reg, quo_reg[plti_pkg::DATA_W-1]};
                alu_b = {2'b00, dr_reg};
            end
            ST_FIX: begin
                alu_a   = plti_pkg::sext_alu(prev_tgt_reg);
                alu_b   = {2'b00, quo_reg};
                alu_sub = neg_reg;
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b1;
            end
        endcase
    end

    assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + plti_pkg::ALU_W'(alu_sub);
    assign alu_neg = ~alu_res + plti_pkg::ALU_W'(1);

    // reference above query: query minus reference goes negative
    assign found      = alu_res[plti_pkg::ALU_W-1];
    assign last_entry = (plti_pkg::CNT_W'(idx_reg + 1'b1) == n_eff);

    // |dv| * dq; below 2^64 since |dv| <= 2^32 and dq < 2^32 - 1
    logic [plti_pkg::MAG_W+plti_pkg::DATA_W-1:0] mul_full;
    assign mul_full = (plti_pkg::MAG_W + plti_pkg::DATA_W)'(mag_reg)
                    * (plti_pkg::MAG_W + plti_pkg::DATA_W)'(dq_reg);

    // ------------------------------------------------------------------
    // Scan index: restart at zero on a query, advance while no breakpoint
    // lies above the query. The table read address follows it.
    // ------------------------------------------------------------------
    always_comb begin
        idx_next = idx_reg;
        if (s_fire && (s_tuser == plti_pkg::OP_QUERY)) begin
            idx_next = '0;
        end else if ((state_reg == ST_SCAN) && !found && !last_entry) begin
            idx_next = plti_pkg::CNT_W'(idx_reg + 1'b1);
        end
    end

    logic [plti_pkg::IDX_W-1:0] rd_addr;
    logic [plti_pkg::IDX_W-1:0] wr_addr;

    assign rd_addr = idx_next[plti_pkg::IDX_W-1:0];
    assign wr_addr = plti_pkg::IDX_W'(s_point_index);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ref_mem[wr_addr] <= s_ref_value;
            tgt_mem[wr_addr] <= s_target_value;
        end
        rd_ref_reg <= ref_mem[rd_addr];
        rd_tgt_reg <= tgt_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Sequencer and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            num_points_reg <= plti_pkg::CNT_W'(1);
            idx_reg        <= '0;
            div_cnt_reg    <= '0;
        end else begin
            idx_reg <= idx_next;
            if (cfg_valid && cfg_ready) begin
                num_points_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        q_reg <= s_query_value;
                        if (s_tuser == plti_pkg::OP_WRITE) begin
                            // write beat: report range check, no lookup
                            result_reg <= '0;
                            seg_reg    <= '0;
                            clamp_reg  <= plti_pkg::CLAMP_NONE;
                            status_reg <= idx_ok ? plti_pkg::STATUS_OK
                                                 : plti_pkg::STATUS_RANGE;
                            state_reg  <= ST_OUT;
                        end else begin
                            status_reg <= plti_pkg::STATUS_OK;
                            state_reg  <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (found) begin
                        seg_reg <= idx_reg;
                        if (idx_reg == '0) begin
                            result_reg <= rd_tgt_reg;
                            clamp_reg  <= plti_pkg::CLAMP_BELOW;
                            state_reg  <= ST_OUT;
                        end else begin
                            clamp_reg  <= plti_pkg::CLAMP_NONE;
                            state_reg  <= ST_DR;
                        end
                    end else begin
                        // hold the breakpoint just passed as the left end
                        prev_ref_reg <= rd_ref_reg;
                        prev_tgt_reg <= rd_tgt_reg;
                        if (last_entry) begin
                            result_reg <= rd_tgt_reg;
                            seg_reg    <= n_eff;
                            clamp_reg  <= plti_pkg::CLAMP_ABOVE;
                            state_reg  <= ST_OUT;
                        end
                    end
                end
                ST_DR: begin
                    dr_reg    <= alu_res[plti_pkg::DATA_W-1:0];
                    state_reg <= ST_DQ;
                end
                ST_DQ: begin
                    dq_reg    <= alu_res[plti_pkg::DATA_W-1:0];
                    state_reg <= ST_DV;
                end
                ST_DV: begin
                    neg_reg   <= alu_res[plti_pkg::ALU_W-1];
                    mag_reg   <= alu_res[plti_pkg::ALU_W-1] ? alu_neg[plti_pkg::MAG_W-1:0]
                                                            : alu_res[plti_pkg::MAG_W-1:0];
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    // upper half stays below dr, so the quotient fits 32 bits
                    rem_reg     <= mul_full[plti_pkg::PROD_W-1:plti_pkg::DATA_W];
                    quo_reg     <= mul_full[plti_pkg::DATA_W-1:0];
                    div_cnt_reg <= '0;
                    state_reg   <= ST_DIV;
                end
                ST_DIV: begin
                    if (!alu_res[plti_pkg::ALU_W-1]) begin
                        rem_reg <= alu_res[plti_pkg::DATA_W-1:0];
                    end else begin
                        rem_reg <= {rem_reg[plti_pkg::DATA_W-2:0],
                                    quo_reg[plti_pkg::DATA_W-1]};
                    end
                    quo_reg     <= {quo_reg[plti_pkg::DATA_W-2:0],
                                    !alu_res[plti_pkg::ALU_W-1]};
                    div_cnt_reg <= plti_pkg::DIV_CNT_W'(div_cnt_reg + 1'b1);
                    if (div_cnt_reg == plti_pkg::DIV_CNT_W'(plti_pkg::DIV_STEPS - 1)) begin
                        state_reg <= ST_FIX;
                    end
                end
                ST_FIX: begin
                    result_reg <= alu_res[plti_pkg::DATA_W-1:0];
                    state_reg  <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output packing
    // ------------------------------------------------------------------
    assign m_tdata = {{(plti_pkg::M_TDATA_W - plti_pkg::DATA_W - plti_pkg::CNT_W){1'b0}},
                      seg_reg, result_reg};
    assign m_tuser = {status_reg, clamp_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PLTI_ASSERT_IMPL(a_one_item, aclk, aresetn, 1'b1, !(s_tready && m_tvalid))
    `PLTI_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_fire, !s_tready)
    `PLTI_ASSERT_IMPL(a_range_err_zero, aclk, aresetn, m_tvalid && status_reg,
        (result_reg == '0) && (seg_reg == '0) && (clamp_reg == plti_pkg::CLAMP_NONE))
    `PLTI_ASSERT_IMPL(a_below_seg0, aclk, aresetn,
        m_tvalid && (clamp_reg == plti_pkg::CLAMP_BELOW), seg_reg == '0)
    `PLTI_ASSERT_NEXT(a_mul_to_div, aclk, aresetn, state_reg == ST_MUL,
        (state_reg == ST_DIV) && (div_cnt_reg == '0))

endmodule

`default_nettype wire
